/* design/axis_position_velocity_controller_assert.svh */
// Assertion macros for the axis controller
`ifndef AXIS_POSITION_VELOCITY_CONTROLLER_ASSERT_SVH
`define AXIS_POSITION_VELOCITY_CONTROLLER_ASSERT_SVH

// check cons in the same cycle as ante
`define APVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("axis controller check failed");

// check cons in the cycle after ante
`define APVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("axis controller check failed");

`endif

/* design/apvc_pkg.sv */
package apvc_pkg;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_TARGET  = 2'd1;
    localparam logic [1:0] KIND_ENABLE  = 2'd2;
    localparam logic [1:0] KIND_DISABLE = 2'd3;

    localparam logic [1:0] V_GOAL = 2'd0;
    localparam logic [1:0] V_ZERO = 2'd1;
    localparam logic [1:0] V_FULL = 2'd2;
    localparam logic [1:0] V_QUOT = 2'd3;

    localparam logic [30:0] TOL_RESET = 31'd66;
    localparam logic [4:0]  DIV_LAST  = 5'd31;

    typedef struct packed {
        logic       load_in;
        logic       apply_simple;
        logic       load_err;
        logic       load_v;
        logic [1:0] v_sel;
        logic       mul_v;
        logic       div_start;
        logic       div_step;
        logic       integrate;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       tick_live;
        logic       pos_mode;
        logic       stop;
        logic       fits;
        logic       div_last;
    } t_status;

    function automatic logic signed [31:0] sat_s32(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -39'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] mag_to_s32(input logic [32:0] m, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            r = (m >= 33'h080000000) ? 32'sh80000000 : 32'(-m[31:0]);
        end else begin
            r = (m > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : m[31:0];
        end
        return r;
    endfunction

endpackage

/* design/apvc_in_if.sv */
interface apvc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [23:0]        delta_time;
    logic               goal_mode;
    logic               goal_relative;
    logic signed [31:0] goal_position;
    logic signed [31:0] goal_velocity;

    modport source (output valid, kind, delta_time, goal_mode, goal_relative,
                    goal_position, goal_velocity, input ready);
    modport sink (input valid, kind, delta_time, goal_mode, goal_relative,
                  goal_position, goal_velocity, output ready);
endinterface

/* design/apvc_out_if.sv */
interface apvc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_velocity;
    logic signed [31:0] axis_position;
    logic               axis_enabled;

    modport source (output valid, drive_velocity, axis_position, axis_enabled,
                    input ready);
    modport sink (input valid, drive_velocity, axis_position, axis_enabled,
                  output ready);
endinterface

/* design/apvc_ctrl.sv */
module apvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  apvc_pkg::t_status i_status,
    output apvc_pkg::t_cmd    o_cmd
);
    import apvc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_MULS   = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_QUOT   = 4'd5;
    localparam logic [3:0] S_MULV   = 4'd6;
    localparam logic [3:0] S_INT    = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.kind != KIND_TICK || !i_status.tick_live) begin
                    o_cmd.apply_simple = 1'b1;
                    n_state = S_EMIT;
                end else if (!i_status.pos_mode) begin
                    o_cmd.load_v = 1'b1;
                    o_cmd.v_sel  = V_GOAL;
                    n_state = S_MULV;
                end else begin
                    o_cmd.load_err = 1'b1;
                    n_state = S_MULS;
                end
            end
            S_MULS: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_status.stop) begin
                    o_cmd.load_v = 1'b1;
                    o_cmd.v_sel  = V_ZERO;
                    n_state = S_MULV;
                end else if (i_status.fits) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.load_v = 1'b1;
                    o_cmd.v_sel  = V_FULL;
                    n_state = S_MULV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                o_cmd.load_v = 1'b1;
                o_cmd.v_sel  = V_QUOT;
                n_state = S_MULV;
            end
            S_MULV: begin
                o_cmd.mul_v = 1'b1;
                n_state = S_INT;
            end
            S_INT: begin
                o_cmd.integrate = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

/* design/apvc_dp.sv */
module apvc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_wdata,
    input  logic [1:0]         i_kind,
    input  logic [23:0]        i_delta_time,
    input  logic               i_goal_mode,
    input  logic               i_goal_relative,
    input  logic signed [31:0] i_goal_position,
    input  logic signed [31:0] i_goal_velocity,
    output logic signed [31:0] o_drive_velocity,
    output logic signed [31:0] o_axis_position,
    output logic               o_axis_enabled,
    input  apvc_pkg::t_cmd     i_cmd,
    output apvc_pkg::t_status  o_status
);
    import apvc_pkg::*;

    logic [30:0]        r_tol;
    logic signed [31:0] r_pos, r_vel, r_goal_pos, r_goal_vel;
    logic               r_goal_mode, r_en;

    logic [1:0]         r_kind;
    logic [23:0]        r_dt;
    logic               r_mode, r_rel;
    logic signed [31:0] r_gpos, r_gvel;

    logic [32:0]        r_aerr;
    logic               r_neg;
    logic [31:0]        r_speed;
    logic signed [57:0] r_prod;
    logic signed [31:0] r_v;
    logic [23:0]        r_rem;
    logic [31:0]        r_dq;
    logic [4:0]         r_cnt;

    logic signed [31:0] r_out_vel, r_out_pos;
    logic               r_out_en;

    logic signed [32:0] err;
    logic signed [32:0] mul_a;
    logic [57:0]        prod_mag;
    logic [37:0]        step;
    logic signed [38:0] n_pos_wide;
    logic signed [31:0] n_pos, n_goal_pos, n_v;
    logic [24:0]        trial;
    logic               ge;

    assign err      = {r_goal_pos[31], r_goal_pos} - {r_pos[31], r_pos};
    assign mul_a    = i_cmd.mul_v ? {r_v[31], r_v} : {1'b0, r_speed};
    assign prod_mag = r_prod[57] ? 58'(-r_prod) : r_prod;
    assign step     = prod_mag[57:20];
    assign trial    = {r_rem, r_dq[31]};
    assign ge       = (trial >= {1'b0, r_dt});

    always_comb begin
        if (r_prod[57]) begin
            n_pos_wide = {{7{r_pos[31]}}, r_pos} - $signed({1'b0, step});
        end else begin
            n_pos_wide = {{7{r_pos[31]}}, r_pos} + $signed({1'b0, step});
        end
        n_pos = sat_s32(n_pos_wide);
    end

    always_comb begin
        if (r_mode && r_rel) begin
            n_goal_pos = sat_s32(39'({{7{r_gpos[31]}}, r_gpos}) + 39'({{7{r_pos[31]}}, r_pos}));
        end else begin
            n_goal_pos = r_gpos;
        end
    end

    always_comb begin
        case (i_cmd.v_sel)
            V_GOAL:  n_v = r_goal_vel;
            V_ZERO:  n_v = '0;
            V_FULL:  n_v = mag_to_s32({1'b0, r_speed}, r_neg);
            default: n_v = mag_to_s32({1'b0, r_dq}, r_neg);
        endcase
    end

    assign o_status.kind      = r_kind;
    assign o_status.tick_live = r_en && (r_dt != '0);
    assign o_status.pos_mode  = r_goal_mode;
    assign o_status.stop      = (r_aerr <= {2'b0, r_tol}) || (r_speed == '0);
    assign o_status.fits      = ({5'b0, r_aerr, 20'b0} <= $unsigned(r_prod));
    assign o_status.div_last  = (r_cnt == DIV_LAST);

    assign o_drive_velocity = r_out_vel;
    assign o_axis_position  = r_out_pos;
    assign o_axis_enabled   = r_out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RESET;
            r_pos       <= '0;
            r_vel       <= '0;
            r_goal_pos  <= '0;
            r_goal_vel  <= '0;
            r_goal_mode <= 1'b0;
            r_en        <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (i_cmd.apply_simple) begin
                case (r_kind)
                    KIND_TARGET: begin
                        r_goal_mode <= r_mode;
                        r_goal_vel  <= r_gvel;
                        r_goal_pos  <= n_goal_pos;
                    end
                    KIND_ENABLE: begin
                        r_en <= 1'b1;
                    end
                    KIND_DISABLE: begin
                        r_en  <= 1'b0;
                        r_vel <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.integrate) begin
                r_vel <= r_v;
                r_pos <= n_pos;
            end
            if (i_cmd.div_start) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, r_dt});
        if (i_cmd.load_in) begin
            r_kind <= i_kind;
            r_dt   <= i_delta_time;
            r_mode <= i_goal_mode;
            r_rel  <= i_goal_relative;
            r_gpos <= i_goal_position;
            r_gvel <= i_goal_velocity;
        end
        if (i_cmd.load_err) begin
            r_neg   <= err[32];
            r_aerr  <= err[32] ? 33'(-err) : err;
            r_speed <= r_goal_vel[31] ? 32'(-r_goal_vel) : r_goal_vel;
        end
        if (i_cmd.load_v) begin
            r_v <= n_v;
        end
        if (i_cmd.div_start) begin
            r_rem <= {3'b0, r_aerr[32:12]};
            r_dq  <= {r_aerr[11:0], 20'b0};
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? 24'(trial - {1'b0, r_dt}) : trial[23:0];
            r_dq  <= {r_dq[30:0], ge};
        end
        if (i_cmd.emit) begin
            r_out_vel <= r_vel;
            r_out_pos <= r_pos;
            r_out_en  <= r_en;
        end
    end
endmodule

/* design/axis_position_velocity_controller.sv */
// Channel  Dir  Handshake      Payload
// i_in     in   valid / ready  kind, delta_time, goal_mode, goal_relative,
//                              goal_position, goal_velocity
// o_out    out  valid / ready  drive_velocity, axis_position, axis_enabled
//
// One item at a time; every item gives one result.
// Set target, enable, disable and idle ticks go from decode straight to emit.
// Velocity-mode tick: multiply, integrate, emit. A position-mode tick first
// may run the 32-step restoring divider that forms error * 2^20 / delta_time.
// Synchronous active-low reset; tolerance resets to 66.
// A stalled result holds the next item in the controller's final state.
`include "axis_position_velocity_controller_assert.svh"

module axis_position_velocity_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    apvc_in_if.sink     i_in,
    apvc_out_if.source  o_out
);
    import apvc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    apvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    apvc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (i_in.kind),
        .i_delta_time     (i_in.delta_time),
        .i_goal_mode      (i_in.goal_mode),
        .i_goal_relative  (i_in.goal_relative),
        .i_goal_position  (i_in.goal_position),
        .i_goal_velocity  (i_in.goal_velocity),
        .o_drive_velocity (o_out.drive_velocity),
        .o_axis_position  (o_out.axis_position),
        .o_axis_enabled   (o_out.axis_enabled),
        .i_cmd            (w_cmd),
        .o_status         (w_status)
    );

    `APVC_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `APVC_ASSERT_NEXT(a_emit_shows_result, i_clk, i_rst_n, w_cmd.emit, o_out.valid)
    `APVC_ASSERT_SAME(a_disabled_at_rest, i_clk, i_rst_n, o_out.valid && !o_out.axis_enabled, o_out.drive_velocity == 32'sd0)
endmodule
